>>> src/nvs_pkg.sv
// ----------------------------------------------------------------------------
// nvs_pkg: shared types and constants for the nearest vertex search block
// Request and result structs, register indexes, opcodes and FSM states.
// ----------------------------------------------------------------------------
package nvs_pkg;

  localparam int FIELD_W    = 24;
  localparam int ID_W       = 10;
  localparam int SEP_W      = 25;
  localparam int DIM_W      = 2;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd1;

  localparam logic [DIM_W-1:0]   DIM_RESET   = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd0;
  localparam logic [SEP_W-1:0]   SEP_MAX     = '1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic [ID_W-1:0]           vertex_index;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;
  } in_req_t;

  typedef struct packed {
    logic [ID_W-1:0]  nearest_id;
    logic [SEP_W-1:0] separation;
  } out_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROOT
  } state_t;

endpackage

>>> src/nearest_vertex_search_top.sv
// ----------------------------------------------------------------------------
// nearest_vertex_search_top: nearest stored vertex by linear scan
// Vertex store with write requests; query requests scan the store under the
// squared Euclidean distance and return the nearest slot and its distance.
// ----------------------------------------------------------------------------
// A write request (opcode 0) stores the vertex; busy stays low. A query
// request (opcode 1) keeps busy high while it runs: the single read port
// of the vertex memory delivers one vertex per cycle into a four-stage
// distance pipeline, and a restoring square root unit of ROOT_W =
// COORD_BITS + 1 result bits then yields one result bit per cycle. The
// result appears on out_rsp with out_strobe high for a single cycle; the
// receiver cannot stall it. Configuration writes are always ready and
// are meant to be issued while busy is low.
module nearest_vertex_search_top
  import nvs_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_req_t               in_req,
  output logic                  out_strobe,
  output out_rsp_t              out_rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = SQ_W + 2;
  localparam int BEST_W    = (SUM_W > 64) ? 64 : SUM_W;
  localparam int ROOT_W    = (BEST_W + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SEP_EXT_W = (ROOT_W > SEP_W) ? ROOT_W : SEP_W;
  localparam int MEM_W     = 3 * COORD_BITS;

  function automatic logic [COORD_BITS-1:0] trim(input logic [FIELD_W-1:0] f);
    logic [31:0] e;
    e = 32'(f);
    return e[COORD_BITS-1:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] d;
    logic [COORD_BITS:0] n;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    n = -d;
    return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  // configuration
  logic [DIM_W-1:0]   dim_r;
  logic [COUNT_W-1:0] cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
      cnt_r <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_DIMENSION) begin
        dim_r <= cfg_data[DIM_W-1:0];
      end else if (cfg_index == REG_VERTEX_COUNT) begin
        cnt_r <= cfg_data[COUNT_W-1:0];
      end
    end
  end

  // request decode
  state_t state_r, state_nxt;
  logic   wr_en;
  logic   q_go;
  logic [31:0] wr_idx32;
  logic [AW-1:0] wr_addr;

  assign busy     = (state_r != ST_IDLE);
  assign q_go     = start && !busy && (in_req.opcode == OP_QUERY);
  assign wr_idx32 = 32'(in_req.vertex_index);
  assign wr_addr  = wr_idx32[AW-1:0];
  assign wr_en    = start && !busy && (in_req.opcode == OP_WRITE) &&
                    (wr_idx32 < 32'(MAX_VERTICES));

  // vertex memory: x, y, z packed per entry
  logic [MEM_W-1:0] mem [MAX_VERTICES];
  logic [MEM_W-1:0] rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {trim(in_req.coord_x), trim(in_req.coord_y), trim(in_req.coord_z)};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // sequencer registers
  logic [CNT_W-1:0]      scan_r, scan_nxt;
  logic [CNT_W-1:0]      lim_r, lim_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [BEST_W-1:0]     best_r, best_nxt;
  logic [AW-1:0]         best_id_r, best_id_nxt;
  logic                  first_r, first_nxt;
  logic [RAD_W-1:0]      rad_n_r, rad_n_nxt;
  logic [RAD_W-1:0]      rad_res_r, rad_res_nxt;
  logic [RAD_W-1:0]      rad_bit_r, rad_bit_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_rsp_t              out_rsp_r, out_rsp_nxt;

  // distance pipeline
  logic                  v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0]         id1_r, id2_r, id3_r, id4_r;
  logic [COORD_BITS-1:0] adx_r, ady_r, adz_r;
  logic [SQ_W-1:0]       sqx_r, sqy_r, sqz_r;
  logic [BEST_W-1:0]     sum4_r;
  logic [SUM_W-1:0]      sum;
  logic [BEST_W-1:0]     sum_sat;
  logic                  use_x, use_y, use_z;

  assign rd_en   = (state_r == ST_SCAN) && (scan_r < lim_r);
  assign rd_addr = scan_r[AW-1:0];
  assign use_x   = (dim_r != 2'd0);
  assign use_y   = dim_r[1];
  assign use_z   = (dim_r == 2'd3);

  assign sum     = SUM_W'(sqx_r) + SUM_W'(sqy_r) + SUM_W'(sqz_r);
  assign sum_sat = ((sum >> BEST_W) != '0) ? {BEST_W{1'b1}} : sum[BEST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    id1_r  <= rd_addr;
    id2_r  <= id1_r;
    id3_r  <= id2_r;
    id4_r  <= id3_r;
    adx_r  <= use_x ? abs_diff(rd_data_r[3*COORD_BITS-1:2*COORD_BITS], px_r) : '0;
    ady_r  <= use_y ? abs_diff(rd_data_r[2*COORD_BITS-1:COORD_BITS], py_r) : '0;
    adz_r  <= use_z ? abs_diff(rd_data_r[COORD_BITS-1:0], pz_r) : '0;
    sqx_r  <= SQ_W'(adx_r) * SQ_W'(adx_r);
    sqy_r  <= SQ_W'(ady_r) * SQ_W'(ady_r);
    sqz_r  <= SQ_W'(adz_r) * SQ_W'(adz_r);
    sum4_r <= sum_sat;
  end

  // next state and datapath control
  logic [31:0]          cnt32;
  logic [31:0]          lim32;
  logic [RAD_W:0]       trial;
  logic [ROOT_W-1:0]    root;
  logic [SEP_EXT_W-1:0] root_ext;
  logic [31:0]          id32;

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    lim_nxt        = lim_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    pz_nxt         = pz_r;
    best_nxt       = best_r;
    best_id_nxt    = best_id_r;
    first_nxt      = first_r;
    rad_n_nxt      = rad_n_r;
    rad_res_nxt    = rad_res_r;
    rad_bit_nxt    = rad_bit_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = out_rsp_r;

    cnt32    = 32'(cnt_r);
    lim32    = (cnt32 > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : cnt32;
    trial    = (RAD_W+1)'(rad_res_r) + (RAD_W+1)'(rad_bit_r);
    root     = rad_res_r[ROOT_W-1:0];
    root_ext = SEP_EXT_W'(root);
    id32     = 32'(best_id_r);

    if (v4_r && (first_r || (sum4_r < best_r))) begin
      best_nxt    = sum4_r;
      best_id_nxt = id4_r;
      first_nxt   = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (q_go) begin
          state_nxt   = ST_SCAN;
          scan_nxt    = '0;
          lim_nxt     = lim32[CNT_W-1:0];
          px_nxt      = trim(in_req.coord_x);
          py_nxt      = trim(in_req.coord_y);
          pz_nxt      = trim(in_req.coord_z);
          best_nxt    = '0;
          best_id_nxt = '0;
          first_nxt   = 1'b1;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          scan_nxt = scan_r + 1'b1;
        end else if (!v1_r && !v2_r && !v3_r && !v4_r) begin
          state_nxt   = ST_ROOT;
          rad_n_nxt   = RAD_W'(best_r);
          rad_res_nxt = '0;
          rad_bit_nxt = RAD_W'(1) << (RAD_W - 2);
        end
      end
      ST_ROOT: begin
        if (rad_bit_r != '0) begin
          if ((RAD_W+1)'(rad_n_r) >= trial) begin
            rad_n_nxt   = rad_n_r - trial[RAD_W-1:0];
            rad_res_nxt = (rad_res_r >> 1) + rad_bit_r;
          end else begin
            rad_res_nxt = rad_res_r >> 1;
          end
          rad_bit_nxt = rad_bit_r >> 2;
        end else begin
          state_nxt              = ST_IDLE;
          out_strobe_nxt         = 1'b1;
          out_rsp_nxt.nearest_id = id32[ID_W-1:0];
          out_rsp_nxt.separation = (root_ext > SEP_EXT_W'(SEP_MAX)) ?
                                   SEP_MAX : root_ext[SEP_W-1:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    lim_r     <= lim_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pz_r      <= pz_nxt;
    best_r    <= best_nxt;
    best_id_r <= best_id_nxt;
    first_r   <= first_nxt;
    rad_n_r   <= rad_n_nxt;
    rad_res_r <= rad_res_nxt;
    rad_bit_r <= rad_bit_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  // checks
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_go |=> busy)
    else $error("query request did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == ST_IDLE))
    else $error("result issued while still busy");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r <= lim_r))
    else $error("scan address past vertex limit");

  a_root_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT) |-> !(v1_r || v2_r || v3_r || v4_r))
    else $error("square root started before distance pipeline drained");

endmodule
